### src/ptts_pkg.sv
package ptts_pkg;

  // Fixed field widths of the command and result words.
  localparam int unsigned OpW      = 2;
  localparam int unsigned SlotIdxW = 4;
  localparam int unsigned FieldW   = 16;
  localparam int unsigned MaskW    = 16;

  // Operation codes carried by the command word.
  typedef enum logic [OpW-1:0] {
    OP_TICK     = 2'd0,
    OP_REGISTER = 2'd1,
    OP_ENABLE   = 2'd2,
    OP_DISABLE  = 2'd3
  } op_e;

  // Controller states.
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_WALK = 1'b1
  } state_e;

  // Status codes of the result word.
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

endpackage

### src/ptts_ram.sv
module ptts_ram #(
  parameter int unsigned WIDTH = 33,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                     wdata_i,
  input  logic                                 re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                     rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/ptts_slot_upd.sv
module ptts_slot_upd #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                   enabled_i,
  input  logic [COUNT_WIDTH:0]   cnt_i,
  input  logic [COUNT_WIDTH-1:0] period_i,
  output logic [COUNT_WIDTH:0]   cnt_o,
  output logic                   fire_o
);

  logic [COUNT_WIDTH:0] cnt_inc;

  // A stored count never exceeds the largest period, so the increment fits.
  assign cnt_inc = cnt_i + (COUNT_WIDTH + 1)'(1);

  always_comb begin
    cnt_o  = cnt_i;
    fire_o = 1'b0;
    if (enabled_i) begin
      if (cnt_inc >= {1'b0, period_i}) begin
        fire_o = 1'b1;
        cnt_o  = '0;
      end else begin
        cnt_o = cnt_inc;
      end
    end
  end

endmodule

### src/periodic_task_tick_scheduler_unit.sv
// Periodic task tick scheduler.
//
// Commands enter on start_i with operation_i, slot_index_i, start_offset_i
// and period_i; a word is taken at a rising edge where start_i is high and
// busy_o is low. Every command returns exactly one result word, shown for
// a single cycle with done_o high on fire_mask_o, assigned_slot_o and
// status_o. The receiver cannot stall, so results are never held back.
// Register, enable and disable commands finish without a walk: the result
// appears in the cycle after acceptance and busy_o stays low throughout.
// A tick reads each slot in use from the slot memory one per cycle,
// updates the counter of each enabled slot and writes it back; its result
// follows the last slot in use, and with no slot in use it comes in the
// cycle after acceptance. busy_o is high while the walk runs, and the
// single read port of the slot memory limits the walk to one slot at a time.
// Reset clears the enable bits, the fill count and the controller; the
// slot memory needs no clearing because a slot's entry is only used once its
// registration has written it.
module periodic_task_tick_scheduler_unit #(
  parameter int unsigned NUM_SLOTS   = 16,
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic [ptts_pkg::OpW-1:0]            operation_i,
  input  logic [ptts_pkg::SlotIdxW-1:0]       slot_index_i,
  input  logic [ptts_pkg::FieldW-1:0]         start_offset_i,
  input  logic [ptts_pkg::FieldW-1:0]         period_i,
  output logic                                done_o,
  output logic [ptts_pkg::MaskW-1:0]          fire_mask_o,
  output logic [ptts_pkg::SlotIdxW-1:0]       assigned_slot_o,
  output logic                                status_o
);

  localparam int unsigned SlotW  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int unsigned UsedW  = $clog2(NUM_SLOTS + 1);
  localparam int unsigned CntW   = COUNT_WIDTH + 1;
  localparam int unsigned EntryW = COUNT_WIDTH + CntW;

  ptts_pkg::state_e state_q, state_d;

  logic [NUM_SLOTS-1:0]          en_q, en_d;
  logic [UsedW-1:0]              used_q, used_d;
  logic [SlotW-1:0]              ptr_q, ptr_d;
  logic [ptts_pkg::MaskW-1:0]    acc_q, acc_d;

  logic                          done_q, done_d;
  logic [ptts_pkg::MaskW-1:0]    fire_q, fire_d;
  logic [ptts_pkg::SlotIdxW-1:0] slot_q, slot_d;
  logic                          status_q, status_d;

  // Slot memory port signals. An entry holds {period, counter}.
  logic              ram_we;
  logic [SlotW-1:0]  ram_waddr;
  logic [EntryW-1:0] ram_wdata;
  logic              ram_re;
  logic [SlotW-1:0]  ram_raddr;
  logic [EntryW-1:0] ram_rdata;

  logic [COUNT_WIDTH-1:0] rd_period;
  logic [CntW-1:0]        rd_cnt;
  logic [CntW-1:0]        upd_cnt;
  logic                   upd_fire;
  logic [ptts_pkg::MaskW-1:0] fire_bit;

  assign rd_period = ram_rdata[EntryW-1:CntW];
  assign rd_cnt    = ram_rdata[CntW-1:0];

  ptts_ram #(
    .WIDTH(EntryW),
    .DEPTH(NUM_SLOTS)
  ) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  ptts_slot_upd #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_slot_upd (
    .enabled_i(en_q[ptr_q]),
    .cnt_i    (rd_cnt),
    .period_i (rd_period),
    .cnt_o    (upd_cnt),
    .fire_o   (upd_fire)
  );

  // Only the first sixteen slots have a place in the fire mask.
  always_comb begin
    fire_bit = '0;
    for (int b = 0; b < ptts_pkg::MaskW; b++) begin
      if (int'(ptr_q) == b) begin
        fire_bit[b] = upd_fire;
      end
    end
  end

  always_comb begin
    state_d  = state_q;
    en_d     = en_q;
    used_d   = used_q;
    ptr_d    = ptr_q;
    acc_d    = acc_q;
    done_d   = 1'b0;
    fire_d   = fire_q;
    slot_d   = slot_q;
    status_d = status_q;

    ram_we    = 1'b0;
    ram_waddr = ptr_q;
    ram_wdata = {rd_period, upd_cnt};
    ram_re    = 1'b0;
    ram_raddr = '0;

    unique case (state_q)
      ptts_pkg::ST_IDLE: begin
        if (start_i) begin
          fire_d   = '0;
          slot_d   = '0;
          status_d = ptts_pkg::STATUS_OK;
          unique case (ptts_pkg::op_e'(operation_i))
            ptts_pkg::OP_TICK: begin
              if (used_q == '0) begin
                done_d = 1'b1;
              end else begin
                // Fetch slot zero; its entry is on the read port next cycle.
                ram_re    = 1'b1;
                ram_raddr = '0;
                ptr_d     = '0;
                acc_d     = '0;
                state_d   = ptts_pkg::ST_WALK;
              end
            end
            ptts_pkg::OP_REGISTER: begin
              done_d = 1'b1;
              if (used_q < UsedW'(NUM_SLOTS)) begin
                ram_we    = 1'b1;
                ram_waddr = used_q[SlotW-1:0];
                ram_wdata = {COUNT_WIDTH'(period_i), CntW'(COUNT_WIDTH'(start_offset_i))};
                en_d[used_q[SlotW-1:0]] = 1'b1;
                slot_d    = ptts_pkg::SlotIdxW'(used_q);
                used_d    = used_q + UsedW'(1);
              end else begin
                status_d = ptts_pkg::STATUS_FULL;
              end
            end
            ptts_pkg::OP_ENABLE, ptts_pkg::OP_DISABLE: begin
              done_d = 1'b1;
              if (int'(slot_index_i) < NUM_SLOTS) begin
                en_d[SlotW'(slot_index_i)] =
                  (ptts_pkg::op_e'(operation_i) == ptts_pkg::OP_ENABLE);
              end
            end
            default: ;
          endcase
        end
      end

      ptts_pkg::ST_WALK: begin
        // Entry of slot ptr_q is on the read port: update and write back,
        // while the next slot is fetched.
        ram_we    = en_q[ptr_q];
        ram_waddr = ptr_q;
        ram_re    = 1'b1;
        ram_raddr = ptr_q + SlotW'(1);
        acc_d     = acc_q | fire_bit;
        if (UsedW'(ptr_q) + UsedW'(1) == used_q) begin
          done_d  = 1'b1;
          fire_d  = acc_q | fire_bit;
          state_d = ptts_pkg::ST_IDLE;
        end else begin
          ptr_d = ptr_q + SlotW'(1);
        end
      end

      default: begin
        state_d = ptts_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ptts_pkg::ST_IDLE;
      en_q    <= '0;
      used_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      en_q    <= en_d;
      used_q  <= used_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q    <= ptr_d;
    acc_q    <= acc_d;
    fire_q   <= fire_d;
    slot_q   <= slot_d;
    status_q <= status_d;
  end

  assign busy_o          = (state_q != ptts_pkg::ST_IDLE);
  assign done_o          = done_q;
  assign fire_mask_o     = fire_q;
  assign assigned_slot_o = slot_q;
  assign status_o        = status_q;

endmodule

### tb/sv/tb_periodic_task_tick_scheduler_unit.sv
`timescale 1ns / 1ps

module tb_periodic_task_tick_scheduler_unit;

  localparam int unsigned SlotCount = 16;
  localparam int unsigned CountW    = 16;

  // Field widths of the command and reply words.
  localparam int unsigned OpW      = ptts_pkg::OpW;
  localparam int unsigned SlotIdxW = ptts_pkg::SlotIdxW;
  localparam int unsigned FieldW   = ptts_pkg::FieldW;
  localparam int unsigned MaskW    = ptts_pkg::MaskW;

  // Upper bound on the length of one tick walk over every slot.
  localparam int unsigned WalkCycles = SlotCount + 1;

  // One reply word as the block reports it.
  typedef struct packed {
    logic [MaskW-1:0]    fire_mask;
    logic [SlotIdxW-1:0] assigned_slot;
    logic                status;
  } reply_t;

  logic                clk_i;
  logic                rst_ni;
  logic                start_i;
  logic                busy_o;
  logic [OpW-1:0]      operation_i;
  logic [SlotIdxW-1:0] slot_index_i;
  logic [FieldW-1:0]   start_offset_i;
  logic [FieldW-1:0]   period_i;
  logic                done_o;
  logic [MaskW-1:0]    fire_mask_o;
  logic [SlotIdxW-1:0] assigned_slot_o;
  logic                status_o;

  periodic_task_tick_scheduler_unit #(
    .NUM_SLOTS  (SlotCount),
    .COUNT_WIDTH(CountW)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .operation_i    (operation_i),
    .slot_index_i   (slot_index_i),
    .start_offset_i (start_offset_i),
    .period_i       (period_i),
    .done_o         (done_o),
    .fire_mask_o    (fire_mask_o),
    .assigned_slot_o(assigned_slot_o),
    .status_o       (status_o)
  );

  // Shadow copy of the slot table. The counter is one bit wider than the
  // period so that a counter loaded with the largest offset can still be
  // incremented without wrapping.
  logic [CountW:0]   slot_count   [SlotCount];
  logic [CountW-1:0] slot_period  [SlotCount];
  bit                slot_enabled [SlotCount];
  int unsigned       slots_in_use;

  // Replies still owed by the block, oldest first.
  reply_t reply_q[$];
  bit     saw_failure;

  always #10 clk_i = ~clk_i;

  // Applies one accepted command word to the shadow table and returns the
  // reply the block must give for it.
  function automatic reply_t apply_command(ptts_pkg::op_e op, logic [SlotIdxW-1:0] idx,
                                           logic [FieldW-1:0] offset,
                                           logic [FieldW-1:0] per);
    reply_t r;
    r.fire_mask     = '0;
    r.assigned_slot = '0;
    r.status        = ptts_pkg::STATUS_OK;
    case (op)
      ptts_pkg::OP_TICK: begin
        // Only registered slots take part; disabled ones keep their count.
        for (int i = 0; i < slots_in_use; i++) begin
          if (slot_enabled[i]) begin
            slot_count[i] = slot_count[i] + 1'b1;
            if (slot_count[i] >= {1'b0, slot_period[i]}) begin
              slot_count[i]  = '0;
              r.fire_mask[i] = 1'b1;
            end
          end
        end
      end
      ptts_pkg::OP_REGISTER: begin
        if (slots_in_use < SlotCount) begin
          slot_period[slots_in_use]  = per;
          slot_count[slots_in_use]   = {1'b0, offset};
          slot_enabled[slots_in_use] = 1'b1;
          r.assigned_slot            = slots_in_use[SlotIdxW-1:0];
          slots_in_use++;
        end else begin
          // A refused registration leaves the table untouched.
          r.status = ptts_pkg::STATUS_FULL;
        end
      end
      default: begin
        // The enable bit is written even for a slot that is not registered.
        slot_enabled[idx] = (op == ptts_pkg::OP_ENABLE);
      end
    endcase
    return r;
  endfunction

  // Presents one command word from a falling edge on and holds it until a
  // rising edge finds the block free. start_i is left high so that a word
  // that follows at once needs only one assignment in its step.
  task automatic issue_word(ptts_pkg::op_e op, logic [SlotIdxW-1:0] idx,
                            logic [FieldW-1:0] offset, logic [FieldW-1:0] per);
    @(negedge clk_i);
    start_i        <= 1'b1;
    operation_i    <= op;
    slot_index_i   <= idx;
    start_offset_i <= offset;
    period_i       <= per;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    reply_q.push_back(apply_command(op, idx, offset, per));
  endtask

  // Drops start_i for the given number of cycles.
  task automatic hold_off(int cycles);
    @(negedge clk_i);
    start_i <= 1'b0;
    repeat (cycles - 1) @(negedge clk_i);
  endtask

  // Stops sending and waits until every owed reply has been checked.
  task automatic wait_for_replies();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (reply_q.size() != 0) @(negedge clk_i);
  endtask

  // Periods are mostly short so that slots fire often within the run; now
  // and then one is drawn over the full range.
  function automatic logic [FieldW-1:0] pick_period();
    if ($urandom_range(99) < 80) return FieldW'($urandom_range(0, 12));
    return FieldW'($urandom_range(16'hFFFF));
  endfunction

  function automatic logic [FieldW-1:0] pick_offset();
    if ($urandom_range(99) < 75) return FieldW'($urandom_range(0, 15));
    return FieldW'($urandom_range(16'hFFFF));
  endfunction

  // A tick on an empty table must report nothing fired.
  task automatic test_idle_tick();
    issue_word(ptts_pkg::OP_TICK, 4'd0, 16'h0000, 16'h0000);
  endtask

  // Enable and disable words addressed to slots not yet registered. Slot 1
  // is disabled here, and its later registration must enable it again.
  task automatic test_unregistered_enables();
    issue_word(ptts_pkg::OP_DISABLE, 4'd15, 16'hFFFF, 16'hFFFF);
    issue_word(ptts_pkg::OP_ENABLE, 4'd3, 16'h0000, 16'h0000);
    issue_word(ptts_pkg::OP_DISABLE, 4'd1, 16'h0000, 16'h0000);
  endtask

  // Period zero fires on every tick, an offset past the period fires on
  // the next tick, and the largest offset with the largest period drives
  // the counter to its top value.
  task automatic test_period_extremes();
    issue_word(ptts_pkg::OP_REGISTER, 4'd9, 16'h0000, 16'h0000);
    issue_word(ptts_pkg::OP_REGISTER, 4'd0, 16'hFFFF, 16'h0001);
    issue_word(ptts_pkg::OP_REGISTER, 4'd0, 16'hFFFF, 16'hFFFF);
    issue_word(ptts_pkg::OP_REGISTER, 4'd0, 16'h0000, 16'hFFFF);
    issue_word(ptts_pkg::OP_REGISTER, 4'd0, 16'h0002, 16'h0003);
    repeat (3) issue_word(ptts_pkg::OP_TICK, 4'd0, 16'h0000, 16'h0000);
  endtask

  // A disabled slot must neither count nor fire until enabled again.
  task automatic test_enable_disable();
    issue_word(ptts_pkg::OP_DISABLE, 4'd0, 16'h0000, 16'h0000);
    issue_word(ptts_pkg::OP_TICK, 4'd0, 16'h0000, 16'h0000);
    issue_word(ptts_pkg::OP_ENABLE, 4'd0, 16'h0000, 16'h0000);
    issue_word(ptts_pkg::OP_DISABLE, 4'd4, 16'h0000, 16'h0000);
    issue_word(ptts_pkg::OP_TICK, 4'd0, 16'h0000, 16'h0000);
    issue_word(ptts_pkg::OP_ENABLE, 4'd4, 16'h0000, 16'h0000);
  endtask

  // Fills whatever is left of the table, then asks for two more slots,
  // which must both be refused. The sender then waits for every reply.
  task automatic test_table_full();
    while (slots_in_use < SlotCount) issue_word(ptts_pkg::OP_REGISTER, 4'd0,
                                                pick_offset(), pick_period());
    issue_word(ptts_pkg::OP_REGISTER, 4'd0, 16'h0000, 16'h0000);
    issue_word(ptts_pkg::OP_REGISTER, 4'd15, 16'hFFFF, 16'hFFFF);
    wait_for_replies();
  endtask

  // Random words with random content. Ticks dominate so that the counters
  // move, and enables and disables are balanced so that about half of the
  // slots stay live. Gaps are mostly short, sometimes long enough to cover
  // a whole tick walk, so that a new word lands on every phase of it.
  task automatic test_random_traffic(int words, int idle_pct);
    int unsigned   roll;
    ptts_pkg::op_e op;
    for (int n = 0; n < words; n++) begin
      roll = $urandom_range(99);
      if (roll < 45)      op = ptts_pkg::OP_TICK;
      else if (roll < 60) op = ptts_pkg::OP_REGISTER;
      else if (roll < 80) op = ptts_pkg::OP_ENABLE;
      else                op = ptts_pkg::OP_DISABLE;
      if (op == ptts_pkg::OP_REGISTER) begin
        issue_word(op, SlotIdxW'($urandom_range(15)), pick_offset(), pick_period());
      end else begin
        issue_word(op, SlotIdxW'($urandom_range(15)), FieldW'($urandom_range(16'hFFFF)),
                   FieldW'($urandom_range(16'hFFFF)));
      end
      if ($urandom_range(99) < idle_pct) begin
        if ($urandom_range(99) < 75) hold_off($urandom_range(1, 4));
        else                         hold_off($urandom_range(5, 20));
      end
    end
  endtask

  // Every reply is compared with the oldest owed one. Outputs are read at
  // the rising edge, so the values are those of the cycle that ends there.
  always @(posedge clk_i) begin : reply_check
    reply_t owed;
    if (rst_ni && done_o === 1'b1) begin
      if (reply_q.size() == 0) begin
        $error("reply word with no command outstanding");
        saw_failure = 1'b1;
      end else begin
        owed = reply_q.pop_front();
        if (fire_mask_o !== owed.fire_mask) begin
          $error("fire_mask: expected %h, got %h", owed.fire_mask, fire_mask_o);
          saw_failure = 1'b1;
        end
        if (assigned_slot_o !== owed.assigned_slot) begin
          $error("assigned_slot: expected %0d, got %0d", owed.assigned_slot,
                 assigned_slot_o);
          saw_failure = 1'b1;
        end
        if (status_o !== owed.status) begin
          $error("status: expected %b, got %b", owed.status, status_o);
          saw_failure = 1'b1;
        end
      end
    end
  end

  initial begin
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    start_i        = 1'b0;
    operation_i    = ptts_pkg::OP_TICK;
    slot_index_i   = '0;
    start_offset_i = '0;
    period_i       = '0;
    saw_failure    = 1'b0;
    slots_in_use   = 0;
    for (int i = 0; i < SlotCount; i++) begin
      slot_count[i]   = '0;
      slot_period[i]  = '0;
      slot_enabled[i] = 1'b0;
    end
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_idle_tick();
    test_unregistered_enables();
    test_period_extremes();
    test_enable_disable();
    test_random_traffic(140, 27);
    test_table_full();
    test_random_traffic(130, 61);
    test_random_traffic(130, 0);

    wait_for_replies();
    repeat (2 * WalkCycles) @(posedge clk_i);
    if (!saw_failure && reply_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Far beyond the slowest correct run: about 450 words, each with a full
  // tick walk and the longest gap, take well under half a millisecond.
  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
